FILE: hw/rtl/ook_remote_frame_transmitter_macros.svh
// ============================================================================
// OOK remote frame transmitter assertion macros
// Shared property wrappers for the port-level checker.
// ============================================================================
`ifndef OOK_REMOTE_FRAME_TRANSMITTER_MACROS_SVH
`define OOK_REMOTE_FRAME_TRANSMITTER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ORFT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("orft check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ORFT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("orft check failed");

`endif

FILE: hw/rtl/orft_pkg.sv
// ============================================================================
// OOK remote frame transmitter package
// Shared types and constants for the frame transmitter modules.
// ============================================================================
package orft_pkg;

    // Width of the register index on the configuration port.
    localparam int CFG_INDEX_BITS = 3;

    // Width of the repeat count register.
    localparam int REPEAT_BITS = 8;

    // Register indexes on the configuration port.
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SHORT_TIME   = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LONG_TIME    = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_START_TIME   = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_REPEAT_COUNT = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_INVERT       = 3'd4;

    // Register reset values.
    localparam int SHORT_TIME_RESET   = 90;
    localparam int LONG_TIME_RESET    = 210;
    localparam int START_TIME_RESET   = 500;
    localparam int REPEAT_COUNT_RESET = 70;

    // Input word command codes.
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_SEND = 1'b1;

    // One result word.
    typedef struct packed {
        logic pin_level;
        logic busy_res;
        logic done_res;
    } result_t;

endpackage

FILE: hw/rtl/orft_cfg_regs.sv
// ============================================================================
// OOK remote frame transmitter configuration registers
// Holds the pulse durations, the repeat count and the level inversion flag.
// ============================================================================
module orft_cfg_regs #(
    parameter int TIME_BITS = 12
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [orft_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [TIME_BITS-1:0]                cfg_data,
    output logic [TIME_BITS-1:0]                short_time,
    output logic [TIME_BITS-1:0]                long_time,
    output logic [TIME_BITS-1:0]                start_time,
    output logic [orft_pkg::REPEAT_BITS-1:0]    repeat_count,
    output logic                                invert
);

    logic [TIME_BITS-1:0]             short_time_reg;
    logic [TIME_BITS-1:0]             long_time_reg;
    logic [TIME_BITS-1:0]             start_time_reg;
    logic [orft_pkg::REPEAT_BITS-1:0] repeat_count_reg;
    logic                             invert_reg;

    // Register writes; indexes beyond the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_time_reg   <= TIME_BITS'(orft_pkg::SHORT_TIME_RESET);
            long_time_reg    <= TIME_BITS'(orft_pkg::LONG_TIME_RESET);
            start_time_reg   <= TIME_BITS'(orft_pkg::START_TIME_RESET);
            repeat_count_reg <= orft_pkg::REPEAT_BITS'(orft_pkg::REPEAT_COUNT_RESET);
            invert_reg       <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                orft_pkg::CFG_SHORT_TIME:   short_time_reg   <= cfg_data;
                orft_pkg::CFG_LONG_TIME:    long_time_reg    <= cfg_data;
                orft_pkg::CFG_START_TIME:   start_time_reg   <= cfg_data;
                orft_pkg::CFG_REPEAT_COUNT:
                    repeat_count_reg <= cfg_data[orft_pkg::REPEAT_BITS-1:0];
                orft_pkg::CFG_INVERT:       invert_reg       <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    assign short_time   = short_time_reg;
    assign long_time    = long_time_reg;
    assign start_time   = start_time_reg;
    assign repeat_count = repeat_count_reg;
    assign invert       = invert_reg;

endmodule

FILE: hw/rtl/orft_seq_core.sv
// ============================================================================
// OOK remote frame transmitter sequencer core
// Frame state registers and the single-pass next-state and level logic.
// ============================================================================
module orft_seq_core #(
    parameter int GROUP_BITS = 16,
    parameter int KEY_BITS   = 8,
    parameter int TIME_BITS  = 12
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             item_take,
    input  logic                             command,
    input  logic [GROUP_BITS-1:0]            group_code,
    input  logic [KEY_BITS-1:0]              key_code,
    input  logic [TIME_BITS-1:0]             short_time,
    input  logic [TIME_BITS-1:0]             long_time,
    input  logic [TIME_BITS-1:0]             start_time,
    input  logic [orft_pkg::REPEAT_BITS-1:0] repeat_count,
    input  logic                             invert,
    output orft_pkg::result_t                result
);

    localparam int CODE_BITS = GROUP_BITS + KEY_BITS;
    localparam int SYM_BITS  = $clog2(CODE_BITS + 1);
    localparam logic [SYM_BITS-1:0] LAST_SYM = SYM_BITS'(CODE_BITS);

    logic                             active_reg, active_next;
    logic [orft_pkg::REPEAT_BITS-1:0] frame_reg, frame_next;
    logic [SYM_BITS-1:0]              sym_reg, sym_next;
    logic                             half_reg, half_next;
    logic [TIME_BITS-1:0]             time_reg, time_next;
    logic [CODE_BITS-1:0]             word_reg, word_next;

    logic [TIME_BITS-1:0] short_dur;
    logic [TIME_BITS-1:0] long_dur;
    logic [TIME_BITS-1:0] start_dur;
    logic [TIME_BITS-1:0] time_dec;
    logic [CODE_BITS-1:0] word_rot;
    logic                 level_cur;

    // A zero duration counts as one tick.
    assign short_dur = (short_time == '0) ? TIME_BITS'(1) : short_time;
    assign long_dur  = (long_time == '0)  ? TIME_BITS'(1) : long_time;
    assign start_dur = (start_time == '0) ? TIME_BITS'(1) : start_time;

    // Timer after this tick, saturating at zero.
    assign time_dec = (time_reg != '0) ? time_reg - TIME_BITS'(1) : '0;

    // The code word rotates left after each data bit, so its MSB is always
    // the current bit and it is back in place at the end of each frame.
    assign word_rot = (sym_reg != '0) ? {word_reg[CODE_BITS-2:0], word_reg[CODE_BITS-1]}
                                      : word_reg;

    // Line level for the state held before this word.
    assign level_cur = active_reg ? (half_reg ? invert : ~invert) : ~invert;

    // Next state and result for one input word.
    always_comb
    begin
        active_next      = active_reg;
        frame_next       = frame_reg;
        sym_next         = sym_reg;
        half_next        = half_reg;
        time_next        = time_reg;
        word_next        = word_reg;
        result.pin_level = level_cur;
        result.busy_res  = active_reg;
        result.done_res  = 1'b0;

        if (command == orft_pkg::CMD_SEND)
        begin
            // A send starts a train only when idle; it takes no time.
            if (!active_reg)
            begin
                word_next   = {group_code, key_code};
                active_next = 1'b1;
                frame_next  = '0;
                sym_next    = '0;
                half_next   = 1'b0;
                time_next   = short_dur;
            end
            result.pin_level = active_reg ? level_cur : ~invert;
            result.busy_res  = 1'b1;
        end
        else if (active_reg)
        begin
            time_next = time_dec;
            if (time_dec == '0)
            begin
                if (!half_reg)
                begin
                    // Move to the inactive half of the symbol.
                    half_next = 1'b1;
                    if (sym_reg == '0)
                    begin
                        time_next = start_dur;
                    end
                    else
                    begin
                        time_next = word_reg[CODE_BITS-1] ? short_dur : long_dur;
                    end
                end
                else
                begin
                    // Move to the active half of the next symbol.
                    half_next = 1'b0;
                    word_next = word_rot;
                    if (sym_reg == LAST_SYM)
                    begin
                        sym_next = '0;
                        if (frame_reg >= repeat_count)
                        begin
                            active_next     = 1'b0;
                            frame_next      = '0;
                            time_next       = '0;
                            result.done_res = 1'b1;
                        end
                        else
                        begin
                            frame_next = frame_reg + orft_pkg::REPEAT_BITS'(1);
                            time_next  = short_dur;
                        end
                    end
                    else
                    begin
                        sym_next  = sym_reg + SYM_BITS'(1);
                        time_next = word_rot[CODE_BITS-1] ? long_dur : short_dur;
                    end
                end
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            frame_reg  <= '0;
            sym_reg    <= '0;
            half_reg   <= 1'b0;
            time_reg   <= '0;
            word_reg   <= '0;
        end
        else if (item_take)
        begin
            active_reg <= active_next;
            frame_reg  <= frame_next;
            sym_reg    <= sym_next;
            half_reg   <= half_next;
            time_reg   <= time_next;
            word_reg   <= word_next;
        end
    end

endmodule

FILE: hw/rtl/orft_out_buf.sv
// ============================================================================
// OOK remote frame transmitter output buffer
// Two-entry result queue that decouples the output stall from the input side.
// ============================================================================
module orft_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  orft_pkg::result_t push_data,
    input  logic              out_stall,
    output logic              out_valid,
    output orft_pkg::result_t out_data,
    output logic              full
);

    orft_pkg::result_t entry_reg [2];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        count_reg, count_next;
    logic              pop;

    assign out_valid = (count_reg != 2'd0);
    assign full      = (count_reg == 2'd2);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign pop       = out_valid && !out_stall;

    // Occupancy after this cycle's push and pop.
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!push && pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    // Pointers and occupancy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    // Result storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: hw/rtl/ook_remote_frame_transmitter.sv
// ============================================================================
// OOK remote frame transmitter
// Pulse-width encoder that sends a group and key code as repeated frames.
//
// Channel   Direction  Handshake           Word
// input     in         in_valid/in_stall   command, group_code, key_code
// output    out        out_valid/out_stall pin_level, busy_res, done_res
// config    in         cfg_write           cfg_index, cfg_data
//
// Each input word passes through the combinational sequencer core, so one word
// can be accepted on every clock while in_stall is low; the result is queued.
// The two-entry result queue sets in_stall only when both entries hold
// results still waiting behind out_stall.
// Reset clears the frame state, the queue and the registers to defaults.
// ============================================================================
module ook_remote_frame_transmitter #(
    parameter int GROUP_BITS = 16,
    parameter int KEY_BITS   = 8,
    parameter int TIME_BITS  = 12
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                command,
    input  logic [GROUP_BITS-1:0]               group_code,
    input  logic [KEY_BITS-1:0]                 key_code,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                pin_level,
    output logic                                busy_res,
    output logic                                done_res,
    input  logic                                cfg_write,
    input  logic [orft_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [TIME_BITS-1:0]                cfg_data
);

    logic [TIME_BITS-1:0]             short_time;
    logic [TIME_BITS-1:0]             long_time;
    logic [TIME_BITS-1:0]             start_time;
    logic [orft_pkg::REPEAT_BITS-1:0] repeat_count;
    logic                             invert;
    logic                             item_take;
    logic                             buf_full;
    orft_pkg::result_t                core_result;
    orft_pkg::result_t                out_result;

    // An input word is taken whenever the result queue has room.
    assign in_stall  = buf_full;
    assign item_take = in_valid && !buf_full;

    // Configuration registers.
    orft_cfg_regs #(
        .TIME_BITS (TIME_BITS)
    ) u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .short_time   (short_time),
        .long_time    (long_time),
        .start_time   (start_time),
        .repeat_count (repeat_count),
        .invert       (invert)
    );

    // Frame sequencer.
    orft_seq_core #(
        .GROUP_BITS (GROUP_BITS),
        .KEY_BITS   (KEY_BITS),
        .TIME_BITS  (TIME_BITS)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_take    (item_take),
        .command      (command),
        .group_code   (group_code),
        .key_code     (key_code),
        .short_time   (short_time),
        .long_time    (long_time),
        .start_time   (start_time),
        .repeat_count (repeat_count),
        .invert       (invert),
        .result       (core_result)
    );

    // Result queue.
    orft_out_buf u_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (item_take),
        .push_data (core_result),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_result),
        .full      (buf_full)
    );

    assign pin_level = out_result.pin_level;
    assign busy_res  = out_result.busy_res;
    assign done_res  = out_result.done_res;

endmodule

FILE: hw/rtl/orft_checker.sv
// ============================================================================
// OOK remote frame transmitter port checker
// Port-level properties of the transmitter, attached to the top level.
// ============================================================================
`include "ook_remote_frame_transmitter_macros.svh"

module orft_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_stall,
    input logic out_valid,
    input logic out_stall,
    input logic pin_level,
    input logic busy_res,
    input logic done_res
);

    // The end of a train is reported on a busy word.
    `ORFT_ASSERT_NOW(a_done_busy, clk, rst_n, out_valid && done_res, busy_res)

    // Input back-pressure only comes from results waiting at the output.
    `ORFT_ASSERT_NOW(a_stall_src, clk, rst_n, in_stall, out_valid)

    // An accepted word always produces a result in the next cycle.
    `ORFT_ASSERT_NEXT(a_accept_out, clk, rst_n, in_valid && !in_stall, out_valid)

    // A stalled result holds.
    `ORFT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(pin_level) && $stable(busy_res) && $stable(done_res))

endmodule

bind ook_remote_frame_transmitter orft_checker u_orft_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .pin_level (pin_level),
    .busy_res  (busy_res),
    .done_res  (done_res)
);

FILE: verif/testbench.sv
// ============================================================================
// OOK remote frame transmitter testbench
// Drives command words through the valid/stall input channel and checks every
// result word against a cycle-free model of the pulse-width frame sequencer.
// A short directed table covers reset levels, inversion, send while busy and
// masked register bits. Random phases then reprogram the timing registers and
// run frame trains with bursty input traffic and a patterned output stall.
// ============================================================================
module testbench;

    localparam int GROUP_W       = 16;
    localparam int KEY_W         = 8;
    localparam int TIME_W        = 12;
    localparam int CODE_W        = GROUP_W + KEY_W;
    localparam int RUN_LIMIT     = 1000000;
    localparam int RANDOM_PHASES = 9;
    localparam int HOLD_PHASE    = 8;
    localparam int PHASE_WORDS   = 70;
    localparam int HOLD_WORDS    = 40;

    // One row of the directed table: either a register write or an input word.
    typedef struct packed {
        logic                                is_cfg;
        logic [orft_pkg::CFG_INDEX_BITS-1:0] idx;
        logic [TIME_W-1:0]                   data;
        logic                                cmd;
        logic [GROUP_W-1:0]                  grp;
        logic [KEY_W-1:0]                    key;
        logic                                chk;
        orft_pkg::result_t                   want;
    } plan_row_t;

    logic                                clk        = 1'b0;
    logic                                rst_n      = 1'b0;
    logic                                in_valid   = 1'b0;
    logic                                in_stall;
    logic                                command    = orft_pkg::CMD_TICK;
    logic [GROUP_W-1:0]                  group_code = '0;
    logic [KEY_W-1:0]                    key_code   = '0;
    logic                                out_valid;
    logic                                out_stall  = 1'b0;
    logic                                pin_level;
    logic                                busy_res;
    logic                                done_res;
    logic                                cfg_write  = 1'b0;
    logic [orft_pkg::CFG_INDEX_BITS-1:0] cfg_index  = orft_pkg::CFG_SHORT_TIME;
    logic [TIME_W-1:0]                   cfg_data   = '0;

    // Shadow registers and frame state of the line model.
    logic [TIME_W-1:0]                t_short;
    logic [TIME_W-1:0]                t_long;
    logic [TIME_W-1:0]                t_start;
    logic [orft_pkg::REPEAT_BITS-1:0] n_repeat;
    logic                             lvl_invert;
    logic                             tx_on;
    logic [7:0]                       frame_no;
    logic [4:0]                       sym_no;
    logic                             in_gap;
    logic [TIME_W-1:0]                ticks_left;
    logic [CODE_W-1:0]                code_reg;

    orft_pkg::result_t line_q [$];
    plan_row_t         plan_q [$];
    int                fail_count = 0;
    int                cyc        = 0;
    int                burst_left = 0;
    int                stall_mode = 0;
    int                stall_span = 0;
    logic              valid_up   = 1'b0;
    logic              cfg_up     = 1'b0;

    ook_remote_frame_transmitter #(
        .GROUP_BITS (GROUP_W),
        .KEY_BITS   (KEY_W),
        .TIME_BITS  (TIME_W)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .command    (command),
        .group_code (group_code),
        .key_code   (key_code),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .pin_level  (pin_level),
        .busy_res   (busy_res),
        .done_res   (done_res),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // Free-running clock with a period of two time units.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Cycle counter and run timeout.
    always @(posedge clk)
    begin
        cyc++;
        if (cyc >= RUN_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Output stall pattern: spans of no stall, light, heavy and periodic stall.
    always @(posedge clk)
    begin
        if (stall_span == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_span <= $urandom_range(16, 96);
        end
        else
        begin
            stall_span <= stall_span - 1;
        end
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            2:       out_stall <= ($urandom_range(0, 4) < 3);
            default: out_stall <= (cyc % 3 == 0);
        endcase
    end

    // A zero duration register still lasts one tick.
    function automatic logic [TIME_W-1:0] seg_len(logic [TIME_W-1:0] t);
        return (t == '0) ? TIME_W'(1) : t;
    endfunction

    // Line level for the current segment; the idle level equals the active one.
    function automatic logic line_level();
        if (!tx_on)
            return !lvl_invert;
        return in_gap ? lvl_invert : !lvl_invert;
    endfunction

    // Load the duration of the half segment that is beginning now.
    function automatic void load_segment();
        logic one_bit;
        one_bit = (sym_no != 0) ? code_reg[CODE_W - sym_no] : 1'b0;
        if (sym_no == 0)
            ticks_left = in_gap ? seg_len(t_start) : seg_len(t_short);
        else if (one_bit)
            ticks_left = in_gap ? seg_len(t_short) : seg_len(t_long);
        else
            ticks_left = in_gap ? seg_len(t_long) : seg_len(t_short);
    endfunction

    // Advance the line model by one accepted word and return its result word.
    function automatic orft_pkg::result_t line_step(logic cmd, logic [GROUP_W-1:0] grp,
                                                    logic [KEY_W-1:0] key);
        orft_pkg::result_t r;
        r.done_res = 1'b0;
        if (cmd == orft_pkg::CMD_SEND)
        begin
            if (!tx_on)
            begin
                code_reg = {grp, key};
                tx_on    = 1'b1;
                frame_no = '0;
                sym_no   = '0;
                in_gap   = 1'b0;
                load_segment();
            end
            r.pin_level = line_level();
            r.busy_res  = tx_on;
        end
        else if (!tx_on)
        begin
            r.pin_level = line_level();
            r.busy_res  = 1'b0;
        end
        else
        begin
            r.pin_level = line_level();
            r.busy_res  = 1'b1;
            if (ticks_left != '0)
                ticks_left--;
            if (ticks_left == '0)
            begin
                if (!in_gap)
                begin
                    in_gap = 1'b1;
                    load_segment();
                end
                else
                begin
                    in_gap = 1'b0;
                    sym_no++;
                    if (sym_no > CODE_W)
                    begin
                        sym_no = '0;
                        // The train ends at the first frame end past the repeat count.
                        if (frame_no >= n_repeat)
                        begin
                            tx_on      = 1'b0;
                            frame_no   = '0;
                            ticks_left = '0;
                            r.done_res = 1'b1;
                        end
                        else
                        begin
                            frame_no++;
                        end
                    end
                    if (tx_on)
                        load_segment();
                end
            end
        end
        return r;
    endfunction

    // Register writes as the block sees them, masked to each register's width.
    function automatic void apply_reg(logic [orft_pkg::CFG_INDEX_BITS-1:0] idx,
                                      logic [TIME_W-1:0] data);
        case (idx)
            orft_pkg::CFG_SHORT_TIME:   t_short    = data;
            orft_pkg::CFG_LONG_TIME:    t_long     = data;
            orft_pkg::CFG_START_TIME:   t_start    = data;
            orft_pkg::CFG_REPEAT_COUNT: n_repeat   = data[orft_pkg::REPEAT_BITS-1:0];
            orft_pkg::CFG_INVERT:       lvl_invert = data[0];
            default:                    ;
        endcase
    endfunction

    function automatic plan_row_t cfg_row(logic [orft_pkg::CFG_INDEX_BITS-1:0] idx,
                                          logic [TIME_W-1:0] data);
        plan_row_t row;
        row        = '0;
        row.is_cfg = 1'b1;
        row.idx    = idx;
        row.data   = data;
        return row;
    endfunction

    function automatic plan_row_t word_row(logic cmd, logic [GROUP_W-1:0] grp,
                                           logic [KEY_W-1:0] key, logic chk,
                                           orft_pkg::result_t want);
        plan_row_t row;
        row      = '0;
        row.cmd  = cmd;
        row.grp  = grp;
        row.key  = key;
        row.chk  = chk;
        row.want = want;
        return row;
    endfunction

    // Offer one input word, wait for it to be taken, then pace the bursts.
    task automatic put_word(logic cmd, logic [GROUP_W-1:0] grp, logic [KEY_W-1:0] key,
                            logic chk, orft_pkg::result_t want);
        orft_pkg::result_t guess;
        int                gap;
        if (cfg_up)
        begin
            cfg_write <= 1'b0;
            cfg_up = 1'b0;
        end
        if (!valid_up)
        begin
            in_valid <= 1'b1;
            valid_up = 1'b1;
        end
        command    <= cmd;
        group_code <= grp;
        key_code   <= key;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        guess = line_step(cmd, grp, key);
        line_q.push_back(chk ? want : guess);
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                valid_up = 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Stop offering words and wait for every expected result word.
    task automatic drain();
        if (valid_up)
        begin
            in_valid <= 1'b0;
            valid_up = 1'b0;
        end
        while (line_q.size() != 0)
            @(posedge clk);
    endtask

    // Write one register once the channel is empty.
    task automatic write_reg(logic [orft_pkg::CFG_INDEX_BITS-1:0] idx,
                             logic [TIME_W-1:0] data);
        drain();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_up = 1'b1;
        @(posedge clk);
        apply_reg(idx, data);
    endtask

    // Result word checker against the oldest expectation.
    always @(posedge clk)
    begin : check_results
        orft_pkg::result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (line_q.size() == 0)
            begin
                $display("%0t: unexpected result word: expected none, got pin %0b busy %0b done %0b",
                         $time, pin_level, busy_res, done_res);
                fail_count++;
            end
            else
            begin
                want = line_q.pop_front();
                if (pin_level !== want.pin_level)
                begin
                    $display("%0t: pin_level expected %0b, got %0b",
                             $time, want.pin_level, pin_level);
                    fail_count++;
                end
                if (busy_res !== want.busy_res)
                begin
                    $display("%0t: busy_res expected %0b, got %0b",
                             $time, want.busy_res, busy_res);
                    fail_count++;
                end
                if (done_res !== want.done_res)
                begin
                    $display("%0t: done_res expected %0b, got %0b",
                             $time, want.done_res, done_res);
                    fail_count++;
                end
            end
        end
    end

    // Stimulus: directed table, then random phases with fresh register settings.
    initial
    begin : stimulus
        plan_row_t          row;
        logic               cmd;
        logic [GROUP_W-1:0] grp;
        logic [KEY_W-1:0]   key;
        int                 words;

        t_short    = TIME_W'(orft_pkg::SHORT_TIME_RESET);
        t_long     = TIME_W'(orft_pkg::LONG_TIME_RESET);
        t_start    = TIME_W'(orft_pkg::START_TIME_RESET);
        n_repeat   = orft_pkg::REPEAT_BITS'(orft_pkg::REPEAT_COUNT_RESET);
        lvl_invert = 1'b0;
        tx_on      = 1'b0;
        frame_no   = '0;
        sym_no     = '0;
        in_gap     = 1'b0;
        ticks_left = '0;
        code_reg   = '0;

        // Idle after reset, inverted idle, zero and masked register values,
        // a send, a send while busy, and inversion flipped during a train.
        plan_q.push_back(word_row(orft_pkg::CMD_TICK, 16'h0000, 8'h00, 1'b1,
                                  '{1'b1, 1'b0, 1'b0}));
        plan_q.push_back(cfg_row(orft_pkg::CFG_INVERT, 12'h001));
        plan_q.push_back(word_row(orft_pkg::CMD_TICK, 16'hFFFF, 8'hFF, 1'b1,
                                  '{1'b0, 1'b0, 1'b0}));
        plan_q.push_back(cfg_row(orft_pkg::CFG_SHORT_TIME, 12'h000));
        plan_q.push_back(cfg_row(orft_pkg::CFG_LONG_TIME, 12'h002));
        plan_q.push_back(cfg_row(orft_pkg::CFG_START_TIME, 12'h001));
        plan_q.push_back(cfg_row(orft_pkg::CFG_REPEAT_COUNT, 12'hF00));
        plan_q.push_back(word_row(orft_pkg::CMD_SEND, 16'hFFFF, 8'hFF, 1'b1,
                                  '{1'b0, 1'b1, 1'b0}));
        plan_q.push_back(word_row(orft_pkg::CMD_SEND, 16'h0000, 8'h00, 1'b1,
                                  '{1'b0, 1'b1, 1'b0}));
        plan_q.push_back(cfg_row(orft_pkg::CFG_INVERT, 12'hFFE));
        plan_q.push_back(word_row(orft_pkg::CMD_TICK, 16'h0000, 8'h00, 1'b1,
                                  '{1'b1, 1'b1, 1'b0}));
        plan_q.push_back(word_row(orft_pkg::CMD_TICK, 16'hFFFF, 8'hFF, 1'b1,
                                  '{1'b0, 1'b1, 1'b0}));
        plan_q.push_back(word_row(orft_pkg::CMD_TICK, 16'h5A5A, 8'hA5, 1'b0, '0));
        plan_q.push_back(word_row(orft_pkg::CMD_TICK, 16'hA5A5, 8'h5A, 1'b0, '0));
        plan_q.push_back(word_row(orft_pkg::CMD_SEND, 16'h1234, 8'h56, 1'b0, '0));
        plan_q.push_back(word_row(orft_pkg::CMD_TICK, 16'h0000, 8'h00, 1'b0, '0));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan_q[i])
        begin
            row = plan_q[i];
            if (row.is_cfg)
                write_reg(row.idx, row.data);
            else
                put_word(row.cmd, row.grp, row.key, row.chk, row.want);
        end

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            if (p == HOLD_PHASE)
            begin
                // Longest durations and repeat count, inverted levels.
                write_reg(orft_pkg::CFG_SHORT_TIME, 12'hFFF);
                write_reg(orft_pkg::CFG_LONG_TIME, 12'hFFF);
                write_reg(orft_pkg::CFG_START_TIME, 12'hFFF);
                write_reg(orft_pkg::CFG_REPEAT_COUNT, 12'hFFF);
                write_reg(orft_pkg::CFG_INVERT, 12'hFFF);
                words = HOLD_WORDS;
            end
            else
            begin
                // Short durations so that whole trains complete within a phase.
                write_reg(orft_pkg::CFG_SHORT_TIME, TIME_W'($urandom_range(0, 2)));
                write_reg(orft_pkg::CFG_LONG_TIME, TIME_W'($urandom_range(0, 3)));
                write_reg(orft_pkg::CFG_START_TIME, TIME_W'($urandom_range(0, 3)));
                write_reg(orft_pkg::CFG_REPEAT_COUNT,
                          TIME_W'(($urandom & 32'hF00) | $urandom_range(0, 2)));
                write_reg(orft_pkg::CFG_INVERT, TIME_W'($urandom & 32'hFFF));
                // Work off a long segment left over from the previous phase.
                words = PHASE_WORDS + ((ticks_left > 50) ? int'(ticks_left) : 0);
            end
            for (int n = 0; n < words; n++)
            begin
                if (tx_on)
                    cmd = ($urandom_range(0, 29) == 0) ? orft_pkg::CMD_SEND
                                                       : orft_pkg::CMD_TICK;
                else
                    cmd = ($urandom_range(0, 1) == 0) ? orft_pkg::CMD_SEND
                                                      : orft_pkg::CMD_TICK;
                case ($urandom_range(0, 7))
                    0:       grp = '0;
                    1:       grp = '1;
                    default: grp = GROUP_W'($urandom);
                endcase
                case ($urandom_range(0, 7))
                    0:       key = '0;
                    1:       key = '1;
                    default: key = KEY_W'($urandom);
                endcase
                put_word(cmd, grp, key, 1'b0, '0);
            end
        end

        drain();
        repeat (4) @(posedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
